// File: rtl/aps_header_parser_top_defines.svh
// Assertion macros used by the parser core RTL.
// Each macro expects signals named clk and rst in the calling module.
`ifndef APS_HEADER_PARSER_TOP_DEFINES_SVH
`define APS_HEADER_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define APS_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("aps parser: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define APS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("aps parser: next-cycle check failed");

`endif

// File: rtl/aps_pkg.sv
`default_nettype none

package aps_pkg;

  localparam int StepW = 4;
  localparam int CountW = 4;

  typedef struct packed {
    logic [7:0]        frame_control;
    logic [7:0]        dst_endpoint;
    logic [15:0]       group_address;
    logic [15:0]       cluster_id;
    logic [15:0]       profile_id;
    logic [7:0]        src_endpoint;
    logic [7:0]        frame_counter;
    logic [1:0]        fragmentation;
    logic [7:0]        block_number;
    logic [7:0]        ack_bits;
    logic [CountW-1:0] header_length;
  } hdr_res_t;

endpackage

`default_nettype wire

// File: rtl/aps_parse_core.sv
`default_nettype none

`include "aps_header_parser_top_defines.svh"

module aps_parse_core
  import aps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] data_byte,
  input  wire logic       frame_start,
  output logic            res_valid,
  output hdr_res_t        res
);

  localparam logic [StepW-1:0] ST_IDLE = 4'd0;
  localparam logic [StepW-1:0] ST_DST  = 4'd1;
  localparam logic [StepW-1:0] ST_GLO  = 4'd2;
  localparam logic [StepW-1:0] ST_GHI  = 4'd3;
  localparam logic [StepW-1:0] ST_CLO  = 4'd4;
  localparam logic [StepW-1:0] ST_CHI  = 4'd5;
  localparam logic [StepW-1:0] ST_PLO  = 4'd6;
  localparam logic [StepW-1:0] ST_PHI  = 4'd7;
  localparam logic [StepW-1:0] ST_SRC  = 4'd8;
  localparam logic [StepW-1:0] ST_CNT  = 4'd9;
  localparam logic [StepW-1:0] ST_EXT  = 4'd10;
  localparam logic [StepW-1:0] ST_BLK  = 4'd11;
  localparam logic [StepW-1:0] ST_ACK  = 4'd12;
  localparam logic [StepW-1:0] ST_DONE = 4'd13;

  localparam logic [1:0] TYPE_DATA  = 2'd0;
  localparam logic [1:0] TYPE_ACK   = 2'd2;
  localparam logic [1:0] MODE_UCST  = 2'd0;
  localparam logic [1:0] MODE_BCST  = 2'd2;
  localparam logic [1:0] MODE_GROUP = 2'd3;

  // Whether the field parsed in step s is carried by this header.
  function automatic logic field_present(logic [StepW-1:0] s, logic [7:0] fc,
                                         logic [1:0] frag);
    logic [1:0] ftype;
    logic [1:0] mode;
    logic       ext;
    logic       p;
    ftype = fc[1:0];
    mode  = fc[3:2];
    ext   = fc[7];
    case (s) inside
      ST_DST:                         p = (mode == MODE_UCST) || (mode == MODE_BCST);
      ST_GLO, ST_GHI:                 p = (mode == MODE_GROUP);
      [ST_CLO:ST_PHI]:                p = (ftype == TYPE_DATA) || (ftype == TYPE_ACK);
      ST_SRC:                         p = (ftype == TYPE_DATA);
      ST_CNT:                         p = 1'b1;
      ST_EXT:                         p = ext;
      ST_BLK:                         p = ext && (frag != 2'd0);
      ST_ACK:                         p = ext && (ftype == TYPE_ACK);
      default:                        p = 1'b0;
    endcase
    return p;
  endfunction

  // First present field after step s, or done when none is left.
  function automatic logic [StepW-1:0] following_step(logic [StepW-1:0] s,
                                                      logic [7:0] fc,
                                                      logic [1:0] frag);
    logic [StepW-1:0] r;
    logic             found;
    r = ST_DONE;
    found = 1'b0;
    for (int t = 1; t <= 12; t++) begin
      if (!found && (StepW'(t) > s) && field_present(StepW'(t), fc, frag)) begin
        r = StepW'(t);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  logic [StepW-1:0]  step, step_next, step_after;
  logic [CountW-1:0] byte_count, byte_count_next;
  logic [7:0]        fc, fc_next;
  logic [7:0]        dst, dst_next;
  logic [15:0]       group, group_next;
  logic [15:0]       cluster, cluster_next;
  logic [15:0]       profile, profile_next;
  logic [7:0]        src, src_next;
  logic [7:0]        counter, counter_next;
  logic [1:0]        frag, frag_next;
  logic [7:0]        block, block_next;
  logic [7:0]        ackbits, ackbits_next;
  logic              active;

  assign active = (step != ST_IDLE) && (step < ST_DONE);

  always_comb begin
    step_next       = step;
    step_after      = ST_IDLE;
    byte_count_next = byte_count;
    fc_next         = fc;
    dst_next        = dst;
    group_next      = group;
    cluster_next    = cluster;
    profile_next    = profile;
    src_next        = src;
    counter_next    = counter;
    frag_next       = frag;
    block_next      = block;
    ackbits_next    = ackbits;
    res_valid       = 1'b0;
    if (fire && frame_start) begin
      byte_count_next = CountW'(1);
      fc_next         = data_byte;
      dst_next        = '0;
      group_next      = '0;
      cluster_next    = '0;
      profile_next    = '0;
      src_next        = '0;
      counter_next    = '0;
      frag_next       = '0;
      block_next      = '0;
      ackbits_next    = '0;
      step_next       = following_step(ST_IDLE, data_byte, 2'd0);
    end else if (fire && active) begin
      case (step)
        ST_DST:  dst_next = data_byte;
        ST_GLO:  group_next[7:0] = data_byte;
        ST_GHI:  group_next[15:8] = data_byte;
        ST_CLO:  cluster_next[7:0] = data_byte;
        ST_CHI:  cluster_next[15:8] = data_byte;
        ST_PLO:  profile_next[7:0] = data_byte;
        ST_PHI:  profile_next[15:8] = data_byte;
        ST_SRC:  src_next = data_byte;
        ST_CNT:  counter_next = data_byte;
        ST_EXT:  frag_next = data_byte[1:0];
        ST_BLK:  block_next = data_byte;
        default: ackbits_next = data_byte;
      endcase
      byte_count_next = byte_count + CountW'(1);
      // The block number test depends on the fragmentation just taken.
      step_after = following_step(step, fc, frag_next);
      if (step_after == ST_DONE) begin
        res_valid = 1'b1;
        step_next = ST_IDLE;
      end else begin
        step_next = step_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= ST_IDLE;
      byte_count <= '0;
    end else begin
      step       <= step_next;
      byte_count <= byte_count_next;
    end
    fc      <= fc_next;
    dst     <= dst_next;
    group   <= group_next;
    cluster <= cluster_next;
    profile <= profile_next;
    src     <= src_next;
    counter <= counter_next;
    frag    <= frag_next;
    block   <= block_next;
    ackbits <= ackbits_next;
  end

  assign res.frame_control = fc_next;
  assign res.dst_endpoint  = dst_next;
  assign res.group_address = group_next;
  assign res.cluster_id    = cluster_next;
  assign res.profile_id    = profile_next;
  assign res.src_endpoint  = src_next;
  assign res.frame_counter = counter_next;
  assign res.fragmentation = frag_next;
  assign res.block_number  = block_next;
  assign res.ack_bits      = ackbits_next;
  assign res.header_length = byte_count_next;

  `APS_ASSERT_IMP(a_len_range, res_valid,
                  (res.header_length >= CountW'(2)) && (res.header_length <= CountW'(11)))
  `APS_ASSERT_NEXT(a_start_opens, fire && frame_start, step != ST_IDLE)
  `APS_ASSERT_NEXT(a_done_idles, res_valid, step == ST_IDLE)
  `APS_ASSERT_NEXT(a_idle_ignores, fire && !frame_start && step == ST_IDLE,
                   $stable(byte_count))

endmodule

`default_nettype wire

// File: rtl/aps_out_reg.sv
`default_nettype none

module aps_out_reg
  import aps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     load,
  input  wire hdr_res_t res_in,
  input  wire logic     out_ready,
  output logic          out_valid,
  output logic          can_load,
  output hdr_res_t      res_q
);

  logic valid_next;

  // The register frees up in the same cycle its word is taken.
  assign can_load = !out_valid || out_ready;

  always_comb begin
    valid_next = out_valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (out_ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_next;
    end
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/aps_header_parser_top.sv
// Header parser for the application support sublayer of a low-rate radio stack.
// Input channel: one header byte per word (data_byte) with frame_start set on
// the frame control byte; frame_start restarts parsing and drops any partial
// header. Bytes that arrive while no header is open are consumed and ignored.
// Output channel: one word per complete header, carrying every decoded field;
// fields absent from the header read zero, and header_length counts the bytes.
// Latency: the result word is valid the cycle after its last header byte is
// accepted. Throughput: one byte per cycle while in_ready is high, set by the
// single combinational parse step from field registers to the output register.
// in_ready is high whenever the output register is empty or being emptied, so
// while a result waits on a stalled out_ready the input is held as well, even
// for bytes that would not complete a header; nothing is dropped.
// Reset (rst, synchronous) empties the output register and returns the parser
// to waiting for a frame start.
`default_nettype none

module aps_header_parser_top
  import aps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        data_byte,
  input  wire logic              frame_start,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             frame_control,
  output logic [7:0]             dst_endpoint,
  output logic [15:0]            group_address,
  output logic [15:0]            cluster_id,
  output logic [15:0]            profile_id,
  output logic [7:0]             src_endpoint,
  output logic [7:0]             frame_counter,
  output logic [1:0]             fragmentation,
  output logic [7:0]             block_number,
  output logic [7:0]             ack_bits,
  output logic [CountW-1:0]      header_length
);

  logic     fire;
  logic     res_valid;
  logic     can_load;
  hdr_res_t res;
  hdr_res_t res_q;

  assign in_ready = can_load;
  assign fire     = in_valid && in_ready;

  aps_parse_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  aps_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (can_load),
    .res_q     (res_q)
  );

  assign frame_control = res_q.frame_control;
  assign dst_endpoint  = res_q.dst_endpoint;
  assign group_address = res_q.group_address;
  assign cluster_id    = res_q.cluster_id;
  assign profile_id    = res_q.profile_id;
  assign src_endpoint  = res_q.src_endpoint;
  assign frame_counter = res_q.frame_counter;
  assign fragmentation = res_q.fragmentation;
  assign block_number  = res_q.block_number;
  assign ack_bits      = res_q.ack_bits;
  assign header_length = res_q.header_length;

endmodule

`default_nettype wire
